FILE: hw/rtl/kstg_pkg.sv
// Shared types, scancode constants and key code values for the scancode decoder.
package kstg_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned CodeW = 7;

    // Scancodes with a fixed meaning.
    localparam logic [ByteW-1:0] SC_EXT_PREFIX  = 8'he0;
    localparam logic [ByteW-1:0] SC_LEFT        = 8'h4b;
    localparam logic [ByteW-1:0] SC_RIGHT       = 8'h4d;
    localparam logic [ByteW-1:0] SC_UP          = 8'h48;
    localparam logic [ByteW-1:0] SC_DOWN        = 8'h50;
    localparam logic [ByteW-1:0] SC_SPACE       = 8'h39;
    localparam logic [ByteW-1:0] SC_RSHIFT_MAKE = 8'h36;
    localparam logic [ByteW-1:0] SC_LSHIFT_MAKE = 8'h2a;
    localparam logic [ByteW-1:0] SC_RSHIFT_BRK  = 8'hb6;
    localparam logic [ByteW-1:0] SC_LSHIFT_BRK  = 8'haa;
    localparam logic [ByteW-1:0] SC_CAPS        = 8'h3a;
    localparam logic [ByteW-1:0] SC_ESCAPE      = 8'h81;
    localparam logic [ByteW-1:0] SC_BACKSPACE   = 8'h0e;
    localparam logic [ByteW-1:0] SC_DIGIT_ONE   = 8'h02;
    localparam logic [ByteW-1:0] SC_DIGIT_NINE  = 8'h0a;
    localparam logic [ByteW-1:0] SC_DIGIT_ZERO  = 8'h0b;
    localparam logic [ByteW-1:0] SC_COMMA       = 8'h33;
    localparam logic [ByteW-1:0] SC_PERIOD      = 8'h34;
    localparam logic [ByteW-1:0] SC_QUOTE       = 8'h0c;
    localparam logic [ByteW-1:0] SC_MINUS       = 8'h35;
    localparam logic [ByteW-1:0] SC_TWO         = 8'h03;
    localparam logic [ByteW-1:0] SC_FIVE        = 8'h06;
    localparam logic [ByteW-1:0] SC_SEVEN       = 8'h08;

    // Key codes.
    localparam logic [CodeW-1:0] KC_DIGIT0    = 7'd0;
    localparam logic [CodeW-1:0] KC_UPPER_A   = 7'd10;
    localparam logic [CodeW-1:0] KC_LOWER_A   = 7'd36;
    localparam logic [CodeW-1:0] KC_SPACE     = 7'd62;
    localparam logic [CodeW-1:0] KC_COLON     = 7'd63;
    localparam logic [CodeW-1:0] KC_SEMI      = 7'd64;
    localparam logic [CodeW-1:0] KC_COMMA     = 7'd65;
    localparam logic [CodeW-1:0] KC_PERIOD    = 7'd66;
    localparam logic [CodeW-1:0] KC_EXCLAIM   = 7'd67;
    localparam logic [CodeW-1:0] KC_QUESTION  = 7'd68;
    localparam logic [CodeW-1:0] KC_APOS      = 7'd69;
    localparam logic [CodeW-1:0] KC_DQUOTE    = 7'd70;
    localparam logic [CodeW-1:0] KC_PERCENT   = 7'd71;
    localparam logic [CodeW-1:0] KC_SLASH     = 7'd72;
    localparam logic [CodeW-1:0] KC_DASH      = 7'd73;
    localparam logic [CodeW-1:0] KC_UNDER     = 7'd74;
    localparam logic [CodeW-1:0] KC_LEFT      = 7'd75;
    localparam logic [CodeW-1:0] KC_RIGHT     = 7'd76;
    localparam logic [CodeW-1:0] KC_UP        = 7'd77;
    localparam logic [CodeW-1:0] KC_DOWN      = 7'd78;
    localparam logic [CodeW-1:0] KC_BACKSPACE = 7'd79;
    localparam logic [CodeW-1:0] KC_ESCAPE    = 7'd80;
    localparam logic [CodeW-1:0] KC_NOTHING   = 7'd81;

    // Modifier flags kept between scancodes.
    typedef struct packed {
        logic lshift;
        logic rshift;
        logic caps;
    } t_flags;

    typedef struct packed {
        logic       hit;
        logic [4:0] idx;
    } t_letter;

    // Alphabet position of a letter key, in the order a..z.
    function automatic t_letter letter_of(input logic [ByteW-1:0] b);
        t_letter r;
        r.hit = 1'b1;
        r.idx = 5'd0;
        case (b)
            8'h1e: r.idx = 5'd0;
            8'h30: r.idx = 5'd1;
            8'h2e: r.idx = 5'd2;
            8'h20: r.idx = 5'd3;
            8'h12: r.idx = 5'd4;
            8'h21: r.idx = 5'd5;
            8'h22: r.idx = 5'd6;
            8'h23: r.idx = 5'd7;
            8'h17: r.idx = 5'd8;
            8'h24: r.idx = 5'd9;
            8'h25: r.idx = 5'd10;
            8'h26: r.idx = 5'd11;
            8'h32: r.idx = 5'd12;
            8'h31: r.idx = 5'd13;
            8'h18: r.idx = 5'd14;
            8'h19: r.idx = 5'd15;
            8'h10: r.idx = 5'd16;
            8'h13: r.idx = 5'd17;
            8'h1f: r.idx = 5'd18;
            8'h14: r.idx = 5'd19;
            8'h16: r.idx = 5'd20;
            8'h2f: r.idx = 5'd21;
            8'h11: r.idx = 5'd22;
            8'h2d: r.idx = 5'd23;
            8'h15: r.idx = 5'd24;
            8'h2c: r.idx = 5'd25;
            default: r.hit = 1'b0;
        endcase
        return r;
    endfunction

endpackage

FILE: hw/rtl/keyboard_scancode_to_glyph.sv
// Top level of the set-1 scancode decoder: input register, lookup, result register.
//
// Usage: each request on the input channel (i_in_valid / o_in_ready) carries one
// scancode, i_first_byte plus i_second_byte, where the second byte only matters
// after the 0xE0 extended prefix. Every request yields exactly one response on the
// output channel (o_out_valid / i_out_ready) with a 7-bit o_key_code: a glyph index
// 0..74, an arrow, backspace or escape code 75..80, or 81 for "nothing".
// Shift and caps-lock scancodes change the modifier flags and answer 81.
// From acceptance to o_out_valid, the request sits in the input register while the
// table lookup, a short combinational path, works out its key code, and the result
// register takes that code once it is free. Throughput is one request per cycle
// while the receiver keeps up; the flags are read and updated as a request moves
// into the result register, so consecutive requests see the effect of the ones
// before them without any bubble.
// When the receiver stalls, the result register holds its response and the
// input register holds the next request; o_in_ready drops only when both are
// full, and rises again in the same cycle the receiver takes the response.
// Reset (i_rst_n low, synchronous) empties both registers and clears the left
// shift, right shift and caps-lock flags.
module keyboard_scancode_to_glyph (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [kstg_pkg::ByteW-1:0] i_first_byte,
    input  logic [kstg_pkg::ByteW-1:0] i_second_byte,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [kstg_pkg::CodeW-1:0] o_key_code
);

    // Input register stage.
    logic                       r_in_vld;
    logic [kstg_pkg::ByteW-1:0] r_first;
    logic [kstg_pkg::ByteW-1:0] r_second;

    // Result register stage.
    logic                       r_out_vld;
    logic [kstg_pkg::CodeW-1:0] r_code;

    // Modifier flags, advanced once per request as it leaves the input stage.
    kstg_pkg::t_flags           r_flags;
    kstg_pkg::t_flags           n_flags;
    logic [kstg_pkg::CodeW-1:0] n_code;

    logic out_free;
    logic advance;

    assign out_free   = !r_out_vld || i_out_ready;
    assign advance    = r_in_vld && out_free;
    assign o_in_ready = !r_in_vld || out_free;

    kstg_decode u_decode (
        .i_first_byte  (r_first),
        .i_second_byte (r_second),
        .i_flags       (r_flags),
        .o_key_code    (n_code),
        .o_flags       (n_flags)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_flags   <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (out_free) begin
                r_out_vld <= r_in_vld;
            end
            if (advance) begin
                r_flags <= n_flags;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_first  <= i_first_byte;
            r_second <= i_second_byte;
        end
        if (advance) begin
            r_code <= n_code;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_key_code  = r_code;

endmodule

FILE: hw/rtl/kstg_decode.sv
// Combinational scancode lookup and modifier flag update for one scancode.
module kstg_decode (
    input  logic [kstg_pkg::ByteW-1:0] i_first_byte,
    input  logic [kstg_pkg::ByteW-1:0] i_second_byte,
    input  kstg_pkg::t_flags           i_flags,
    output logic [kstg_pkg::CodeW-1:0] o_key_code,
    output kstg_pkg::t_flags           o_flags
);

    kstg_pkg::t_letter letter;
    logic              shifted;

    assign letter  = kstg_pkg::letter_of(i_first_byte);
    assign shifted = i_flags.lshift | i_flags.rshift | i_flags.caps;

    always_comb begin
        o_flags    = i_flags;
        o_key_code = kstg_pkg::KC_NOTHING;
        if (i_first_byte == kstg_pkg::SC_EXT_PREFIX) begin
            // Only the four arrows exist among extended codes; flags stay.
            case (i_second_byte)
                kstg_pkg::SC_LEFT:  o_key_code = kstg_pkg::KC_LEFT;
                kstg_pkg::SC_RIGHT: o_key_code = kstg_pkg::KC_RIGHT;
                kstg_pkg::SC_UP:    o_key_code = kstg_pkg::KC_UP;
                kstg_pkg::SC_DOWN:  o_key_code = kstg_pkg::KC_DOWN;
                default:            o_key_code = kstg_pkg::KC_NOTHING;
            endcase
        end else begin
            // Modifier codes never appear in the glyph tables, so the flags
            // can be updated independently of the lookup.
            case (i_first_byte)
                kstg_pkg::SC_LSHIFT_MAKE: o_flags.lshift = 1'b1;
                kstg_pkg::SC_RSHIFT_MAKE: o_flags.rshift = 1'b1;
                kstg_pkg::SC_LSHIFT_BRK:  o_flags.lshift = 1'b0;
                kstg_pkg::SC_RSHIFT_BRK:  o_flags.rshift = 1'b0;
                kstg_pkg::SC_CAPS:        o_flags.caps   = ~i_flags.caps;
                default:                  o_flags        = i_flags;
            endcase

            // Keys shared by both tables.
            case (i_first_byte)
                kstg_pkg::SC_SPACE:     o_key_code = kstg_pkg::KC_SPACE;
                kstg_pkg::SC_BACKSPACE: o_key_code = kstg_pkg::KC_BACKSPACE;
                kstg_pkg::SC_ESCAPE:    o_key_code = kstg_pkg::KC_ESCAPE;
                default:                o_key_code = kstg_pkg::KC_NOTHING;
            endcase

            if (letter.hit) begin
                o_key_code = (shifted ? kstg_pkg::KC_UPPER_A : kstg_pkg::KC_LOWER_A)
                             + {2'b00, letter.idx};
            end else if (!shifted) begin
                if (i_first_byte inside {[kstg_pkg::SC_DIGIT_ONE:kstg_pkg::SC_DIGIT_NINE]})
                begin
                    o_key_code = i_first_byte[kstg_pkg::CodeW-1:0] - 7'd1;
                end else begin
                    case (i_first_byte)
                        kstg_pkg::SC_DIGIT_ZERO: o_key_code = kstg_pkg::KC_DIGIT0;
                        kstg_pkg::SC_COMMA:      o_key_code = kstg_pkg::KC_COMMA;
                        kstg_pkg::SC_PERIOD:     o_key_code = kstg_pkg::KC_PERIOD;
                        kstg_pkg::SC_QUOTE:      o_key_code = kstg_pkg::KC_APOS;
                        kstg_pkg::SC_MINUS:      o_key_code = kstg_pkg::KC_DASH;
                        default:                 ;
                    endcase
                end
            end else begin
                case (i_first_byte)
                    kstg_pkg::SC_PERIOD:    o_key_code = kstg_pkg::KC_COLON;
                    kstg_pkg::SC_COMMA:     o_key_code = kstg_pkg::KC_SEMI;
                    kstg_pkg::SC_DIGIT_ONE: o_key_code = kstg_pkg::KC_EXCLAIM;
                    kstg_pkg::SC_QUOTE:     o_key_code = kstg_pkg::KC_QUESTION;
                    kstg_pkg::SC_TWO:       o_key_code = kstg_pkg::KC_DQUOTE;
                    kstg_pkg::SC_FIVE:      o_key_code = kstg_pkg::KC_PERCENT;
                    kstg_pkg::SC_SEVEN:     o_key_code = kstg_pkg::KC_SLASH;
                    kstg_pkg::SC_MINUS:     o_key_code = kstg_pkg::KC_UNDER;
                    default:                ;
                endcase
            end
        end
    end

endmodule

FILE: verif/tb_keyboard_scancode_to_glyph.sv
`timescale 1ns / 1ps
// Self-checking testbench for the set-1 keyboard scancode decoder.
module tb_keyboard_scancode_to_glyph;

    // One outstanding request: the scancode sent and the key code it must give.
    typedef struct {
        logic [kstg_pkg::ByteW-1:0] first_b;
        logic [kstg_pkg::ByteW-1:0] second_b;
        logic [kstg_pkg::CodeW-1:0] code;
    } t_pending_glyph;

    logic                       i_clk;
    logic                       i_rst_n       = 1'b0;
    logic                       i_in_valid    = 1'b0;
    logic                       o_in_ready;
    logic [kstg_pkg::ByteW-1:0] i_first_byte  = '0;
    logic [kstg_pkg::ByteW-1:0] i_second_byte = '0;
    logic                       o_out_valid;
    logic                       i_out_ready   = 1'b0;
    logic [kstg_pkg::CodeW-1:0] o_key_code;

    // Modifier flags as the decoder should hold them after every accepted request.
    kstg_pkg::t_flags kbd_flags;
    t_pending_glyph   pending_glyphs[$];

    int error_count    = 0;
    int requests_sent  = 0;
    // Set while the testbench holds i_in_valid high, so that lowering it is
    // scheduled at most once per time step.
    bit offer_active   = 1'b0;
    // Quiet flags switch off random idling on each side.
    bit sender_quiet   = 1'b0;
    bit receiver_quiet = 1'b0;
    // A nonzero value asks the receiver to hold off; the value sets how long.
    int stall_request  = 0;

    // Scancodes of the letters a..z, in alphabetical order.
    localparam logic [kstg_pkg::ByteW-1:0] LETTER_SCANS [26] = '{
        8'h1e, 8'h30, 8'h2e, 8'h20, 8'h12, 8'h21, 8'h22, 8'h23, 8'h17, 8'h24, 8'h25,
        8'h26, 8'h32, 8'h31, 8'h18, 8'h19, 8'h10, 8'h13, 8'h1f, 8'h14, 8'h16, 8'h2f,
        8'h11, 8'h2d, 8'h15, 8'h2c
    };

    keyboard_scancode_to_glyph uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_first_byte  (i_first_byte),
        .i_second_byte (i_second_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_key_code    (o_key_code)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Works out the key code of one scancode and applies its effect on the
    // modifier flags, in the order the decoder sees the requests.
    function automatic logic [kstg_pkg::CodeW-1:0] predict_key_code(
        input logic [kstg_pkg::ByteW-1:0] first_b,
        input logic [kstg_pkg::ByteW-1:0] second_b);
        int                         letter_idx;
        logic [kstg_pkg::ByteW-1:0] digit_code;
        logic [kstg_pkg::CodeW-1:0] letter_off;
        letter_idx = -1;
        // Extended codes only name the four arrows and never touch the flags.
        if (first_b == kstg_pkg::SC_EXT_PREFIX) begin
            case (second_b)
                kstg_pkg::SC_LEFT:  return kstg_pkg::KC_LEFT;
                kstg_pkg::SC_RIGHT: return kstg_pkg::KC_RIGHT;
                kstg_pkg::SC_UP:    return kstg_pkg::KC_UP;
                kstg_pkg::SC_DOWN:  return kstg_pkg::KC_DOWN;
                default:            return kstg_pkg::KC_NOTHING;
            endcase
        end
        for (int i = 0; i < 26; i++) begin
            if (LETTER_SCANS[i] == first_b) letter_idx = i;
        end
        letter_off = letter_idx[kstg_pkg::CodeW-1:0];
        if (!(kbd_flags.lshift || kbd_flags.rshift || kbd_flags.caps)) begin
            if (letter_idx >= 0) return kstg_pkg::KC_LOWER_A + letter_off;
            // Keys 1..9 sit on consecutive scancodes starting one above the digit.
            if (first_b >= kstg_pkg::SC_DIGIT_ONE && first_b <= kstg_pkg::SC_DIGIT_NINE) begin
                digit_code = first_b - 8'd1;
                return digit_code[kstg_pkg::CodeW-1:0];
            end
            case (first_b)
                kstg_pkg::SC_DIGIT_ZERO: return kstg_pkg::KC_DIGIT0;
                kstg_pkg::SC_COMMA:      return kstg_pkg::KC_COMMA;
                kstg_pkg::SC_PERIOD:     return kstg_pkg::KC_PERIOD;
                kstg_pkg::SC_QUOTE:      return kstg_pkg::KC_APOS;
                kstg_pkg::SC_MINUS:      return kstg_pkg::KC_DASH;
                default: ;
            endcase
        end else begin
            // Caps lock selects the shifted table just like either shift key,
            // so digits without a shifted symbol fall through to nothing.
            if (letter_idx >= 0) return kstg_pkg::KC_UPPER_A + letter_off;
            case (first_b)
                kstg_pkg::SC_PERIOD:    return kstg_pkg::KC_COLON;
                kstg_pkg::SC_COMMA:     return kstg_pkg::KC_SEMI;
                kstg_pkg::SC_DIGIT_ONE: return kstg_pkg::KC_EXCLAIM;
                kstg_pkg::SC_QUOTE:     return kstg_pkg::KC_QUESTION;
                kstg_pkg::SC_TWO:       return kstg_pkg::KC_DQUOTE;
                kstg_pkg::SC_FIVE:      return kstg_pkg::KC_PERCENT;
                kstg_pkg::SC_SEVEN:     return kstg_pkg::KC_SLASH;
                kstg_pkg::SC_MINUS:     return kstg_pkg::KC_UNDER;
                default: ;
            endcase
        end
        case (first_b)
            kstg_pkg::SC_SPACE:       return kstg_pkg::KC_SPACE;
            kstg_pkg::SC_LSHIFT_MAKE: kbd_flags.lshift = 1'b1;
            kstg_pkg::SC_RSHIFT_MAKE: kbd_flags.rshift = 1'b1;
            kstg_pkg::SC_LSHIFT_BRK:  kbd_flags.lshift = 1'b0;
            kstg_pkg::SC_RSHIFT_BRK:  kbd_flags.rshift = 1'b0;
            kstg_pkg::SC_BACKSPACE:   return kstg_pkg::KC_BACKSPACE;
            kstg_pkg::SC_ESCAPE:      return kstg_pkg::KC_ESCAPE;
            kstg_pkg::SC_CAPS:        kbd_flags.caps = ~kbd_flags.caps;
            default: ;
        endcase
        return kstg_pkg::KC_NOTHING;
    endfunction

    // A key that shows up in ordinary text: letters, digits and punctuation.
    function automatic logic [kstg_pkg::ByteW-1:0] pick_typing_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return LETTER_SCANS[$urandom_range(0, 25)];
        if (roll < 80)
            return 8'($urandom_range(kstg_pkg::SC_DIGIT_ONE, kstg_pkg::SC_DIGIT_ZERO));
        case ($urandom_range(0, 3))
            0:       return kstg_pkg::SC_COMMA;
            1:       return kstg_pkg::SC_PERIOD;
            2:       return kstg_pkg::SC_QUOTE;
            default: return kstg_pkg::SC_MINUS;
        endcase
    endfunction

    function automatic logic [kstg_pkg::ByteW-1:0] pick_arrow();
        case ($urandom_range(0, 3))
            0:       return kstg_pkg::SC_LEFT;
            1:       return kstg_pkg::SC_RIGHT;
            2:       return kstg_pkg::SC_UP;
            default: return kstg_pkg::SC_DOWN;
        endcase
    endfunction

    // Offers one request and returns at the edge that accepts it, with valid
    // still high so that the next request can follow without a bubble.
    task automatic send_scancode(input logic [kstg_pkg::ByteW-1:0] first_b,
                                 input logic [kstg_pkg::ByteW-1:0] second_b);
        int gap;
        gap = 0;
        // Each cycle before the offer is idle with a one in four chance.
        while (!sender_quiet && $urandom_range(0, 99) < 25) gap++;
        if (gap > 0) begin
            if (offer_active) begin
                i_in_valid   <= 1'b0;
                offer_active = 1'b0;
            end
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_first_byte  <= first_b;
        i_second_byte <= second_b;
        offer_active  = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        pending_glyphs.push_back('{first_b, second_b, predict_key_code(first_b, second_b)});
        requests_sent++;
    endtask

    task automatic stop_offering();
        if (offer_active) begin
            i_in_valid   <= 1'b0;
            offer_active = 1'b0;
        end
    endtask

    // Waits until every expected response has come, then lets the pipeline settle.
    task automatic wait_for_drain(input int settle_cycles);
        int waited;
        waited = 0;
        while (pending_glyphs.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (settle_cycles) @(posedge i_clk);
    endtask

    task automatic report_error(input string msg);
        if (error_count < 10) $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Extremes of both bytes, each arrow, every table and every special key,
    // with both shift keys and caps lock taken through their states.
    task automatic test_directed();
        send_scancode(8'h00, 8'h00);
        send_scancode(8'hff, 8'hff);
        send_scancode(kstg_pkg::SC_EXT_PREFIX, kstg_pkg::SC_LEFT);
        send_scancode(kstg_pkg::SC_EXT_PREFIX, kstg_pkg::SC_RIGHT);
        send_scancode(kstg_pkg::SC_EXT_PREFIX, kstg_pkg::SC_UP);
        send_scancode(kstg_pkg::SC_EXT_PREFIX, kstg_pkg::SC_DOWN);
        // An extended shift code must not change the flags.
        send_scancode(kstg_pkg::SC_EXT_PREFIX, kstg_pkg::SC_LSHIFT_MAKE);
        send_scancode(kstg_pkg::SC_DIGIT_ONE, 8'hff);
        send_scancode(kstg_pkg::SC_DIGIT_NINE, 8'h00);
        send_scancode(kstg_pkg::SC_DIGIT_ZERO, kstg_pkg::SC_LEFT);
        send_scancode(kstg_pkg::SC_COMMA, 8'h00);
        send_scancode(kstg_pkg::SC_QUOTE, 8'h00);
        send_scancode(kstg_pkg::SC_MINUS, 8'h00);
        send_scancode(kstg_pkg::SC_SPACE, 8'h00);
        send_scancode(kstg_pkg::SC_BACKSPACE, 8'h00);
        send_scancode(kstg_pkg::SC_ESCAPE, 8'h00);
        // A break code of a letter gives nothing.
        send_scancode(8'h9e, 8'h00);
        send_scancode(kstg_pkg::SC_LSHIFT_MAKE, 8'h00);
        send_scancode(LETTER_SCANS[0], 8'h00);
        // A digit with no shifted symbol gives nothing while shifted.
        send_scancode(8'h04, 8'h00);
        send_scancode(kstg_pkg::SC_LSHIFT_BRK, 8'h00);
        send_scancode(kstg_pkg::SC_RSHIFT_MAKE, 8'h00);
        send_scancode(kstg_pkg::SC_PERIOD, 8'h00);
        send_scancode(kstg_pkg::SC_RSHIFT_BRK, 8'h00);
        send_scancode(kstg_pkg::SC_CAPS, 8'h00);
        send_scancode(kstg_pkg::SC_DIGIT_ONE, 8'h00);
        send_scancode(kstg_pkg::SC_CAPS, 8'h00);
    endtask

    // Words of text with shift held around some of them, caps lock toggled
    // now and then, and arrows, editing keys and break codes between words.
    task automatic test_typing(input int n_requests);
        int target;
        int word_len;
        bit use_shift;
        bit left_side;
        target = requests_sent + n_requests;
        while (requests_sent < target) begin
            use_shift = ($urandom_range(0, 99) < 30);
            left_side = $urandom_range(0, 1);
            if (use_shift)
                send_scancode(left_side ? kstg_pkg::SC_LSHIFT_MAKE : kstg_pkg::SC_RSHIFT_MAKE,
                              8'($urandom_range(0, 255)));
            if ($urandom_range(0, 99) < 10)
                send_scancode(kstg_pkg::SC_CAPS, 8'($urandom_range(0, 255)));
            word_len = $urandom_range(1, 8);
            repeat (word_len) send_scancode(pick_typing_key(), 8'($urandom_range(0, 255)));
            // Now and then a shift break goes missing and the shift stays held.
            if (use_shift && $urandom_range(0, 9) != 0)
                send_scancode(left_side ? kstg_pkg::SC_LSHIFT_BRK : kstg_pkg::SC_RSHIFT_BRK,
                              8'($urandom_range(0, 255)));
            case ($urandom_range(0, 9))
                0: send_scancode(kstg_pkg::SC_EXT_PREFIX, pick_arrow());
                1: send_scancode(kstg_pkg::SC_BACKSPACE, 8'($urandom_range(0, 255)));
                2: send_scancode(kstg_pkg::SC_ESCAPE, 8'($urandom_range(0, 255)));
                3: send_scancode(pick_typing_key() | 8'h80, 8'($urandom_range(0, 255)));
                default: send_scancode(kstg_pkg::SC_SPACE, 8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    // Arbitrary bytes, with the extended prefix made common.
    task automatic test_random_bytes(input int n_requests);
        logic [kstg_pkg::ByteW-1:0] first_b;
        logic [kstg_pkg::ByteW-1:0] second_b;
        repeat (n_requests) begin
            first_b  = ($urandom_range(0, 99) < 20) ? kstg_pkg::SC_EXT_PREFIX
                                                     : 8'($urandom_range(0, 255));
            second_b = ($urandom_range(0, 99) < 30) ? pick_arrow() : 8'($urandom_range(0, 255));
            send_scancode(first_b, second_b);
        end
    endtask

    // A long stretch at full rate on both sides.
    task automatic test_full_rate();
        sender_quiet   = 1'b1;
        receiver_quiet = 1'b1;
        test_typing(250);
        sender_quiet   = 1'b0;
        receiver_quiet = 1'b0;
    endtask

    // The receiver holds off while requests keep coming, so both pipeline
    // registers fill and o_in_ready has to drop.
    task automatic test_backpressure();
        sender_quiet  = 1'b1;
        stall_request = 80;
        repeat (30) send_scancode(pick_typing_key(), 8'($urandom_range(0, 255)));
        sender_quiet  = 1'b0;
    endtask

    // The sender stops until the decoder has answered everything, then resumes.
    task automatic test_drain_pause();
        repeat (3) begin
            test_typing(25);
            stop_offering();
            wait_for_drain(4);
        end
    endtask

    // Response checker. Outputs are sampled at the edge, before the decoder's
    // registers update.
    initial begin
        t_pending_glyph head;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (pending_glyphs.size() == 0) begin
                    report_error($sformatf("response %0d with no request outstanding",
                                           o_key_code));
                end else begin
                    head = pending_glyphs.pop_front();
                    if (o_key_code !== head.code)
                        report_error($sformatf(
                            "scancode %h %h: key code expected %0d, got %0d",
                            head.first_b, head.second_b, head.code, o_key_code));
                end
            end
        end
    end

    // Receiver: picks i_out_ready for the next cycle and counts out long holds.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (stall_request > 0) begin
                hold_left     = stall_request - 1;
                stall_request = 0;
                i_out_ready   <= 1'b0;
            end else begin
                i_out_ready <= receiver_quiet || ($urandom_range(0, 99) >= 25);
            end
        end
    end

    initial begin
        kbd_flags = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_typing(1000);
        test_random_bytes(500);
        test_full_rate();
        test_backpressure();
        test_drain_pause();
        stop_offering();
        wait_for_drain(8);
        if (pending_glyphs.size() != 0)
            report_error($sformatf("%0d responses never arrived", pending_glyphs.size()));
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
